@@ hdl/path_command_to_cubic_bezier_unit_macros.svh @@
`ifndef PATH_COMMAND_TO_CUBIC_BEZIER_UNIT_MACROS_SVH
`define PATH_COMMAND_TO_CUBIC_BEZIER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PCB_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PCB_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ hdl/pcb_pkg.sv @@
package pcb_pkg;

    localparam int COORD_W = 32;
    // blend numerator 2u + v + bias, kept non-negative
    localparam int SUM_W = COORD_W + 2;
    // reciprocal of 3 as a sum of powers of four, built by doubling
    localparam int RECIP_STEPS = $clog2((SUM_W + 1) / 2);
    localparam int RECIP_DIGITS = 1 << RECIP_STEPS;
    localparam int PROD_W = SUM_W + 2 * RECIP_DIGITS;
    localparam int DIV_LAT = RECIP_STEPS + 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [SUM_W-1:0] sum_t;

    localparam logic [3:0] MODE_MOVE    = 4'd0;
    localparam logic [3:0] MODE_LINE    = 4'd1;
    localparam logic [3:0] MODE_HORIZ   = 4'd2;
    localparam logic [3:0] MODE_VERT    = 4'd3;
    localparam logic [3:0] MODE_QUAD    = 4'd4;
    localparam logic [3:0] MODE_SQUAD   = 4'd5;
    localparam logic [3:0] MODE_CUBIC   = 4'd6;
    localparam logic [3:0] MODE_SCUBIC  = 4'd7;
    localparam logic [3:0] MODE_CLOSE   = 4'd8;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_QUAD  = 2'd1;
    localparam logic [1:0] KIND_CUBIC = 2'd2;

    typedef struct packed {
        logic [3:0] mode;
        logic       relative;
        coord_t     a_x;
        coord_t     a_y;
        coord_t     b_x;
        coord_t     b_y;
        coord_t     c_x;
        coord_t     c_y;
    } seg_t;

    typedef struct packed {
        coord_t p0_x;
        coord_t p0_y;
        coord_t p1_x;
        coord_t p1_y;
        coord_t p2_x;
        coord_t p2_y;
        coord_t p3_x;
        coord_t p3_y;
    } bez_t;

    typedef struct packed {
        coord_t p0_x;
        coord_t p0_y;
        coord_t p3_x;
        coord_t p3_y;
    } ends_t;

    typedef struct packed {
        logic  emit;
        ends_t ends;
        sum_t  n1_x;
        sum_t  n1_y;
        sum_t  n2_x;
        sum_t  n2_y;
    } blend_job_t;

endpackage

@@ hdl/pcb_state.sv @@
module pcb_state (
    input  logic               clk,
    input  logic               rst_n,
    input  pcb_pkg::seg_t      item,
    input  logic               item_vld,
    input  logic               fire,
    output pcb_pkg::blend_job_t job
);
    import pcb_pkg::*;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    // 3 * 2^(W-1) lifts every numerator to zero or above, +1 turns floor into round
    localparam sum_t BLEND_BIAS = (sum_t'(3) << (COORD_W - 1)) + sum_t'(1);

    function automatic coord_t sat_add(coord_t a, coord_t b);
        logic [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1])
            return s[COORD_W] ? COORD_MIN : COORD_MAX;
        return s[COORD_W-1:0];
    endfunction

    // 2c - k, saturated
    function automatic coord_t reflect(coord_t c, coord_t k);
        logic [COORD_W+1:0] d;
        d = {c[COORD_W-1], c, 1'b0} - {{2{k[COORD_W-1]}}, k};
        if (d[COORD_W+1:COORD_W-1] != 3'b000 && d[COORD_W+1:COORD_W-1] != 3'b111)
            return d[COORD_W+1] ? COORD_MIN : COORD_MAX;
        return d[COORD_W-1:0];
    endfunction

    function automatic sum_t blend_num(coord_t u, coord_t v);
        return {u[COORD_W-1], u, 1'b0} + {{2{v[COORD_W-1]}}, v} + BLEND_BIAS;
    endfunction

    coord_t cur_x_reg, cur_y_reg, start_x_reg, start_y_reg, refl_x_reg, refl_y_reg;
    logic [1:0] kind_reg;
    coord_t cur_x_next, cur_y_next, start_x_next, start_y_next, refl_x_next, refl_y_next;
    logic [1:0] kind_next;

    coord_t off_x, off_y;
    coord_t g_ax, g_ay, g_bx, g_by, g_cx, g_cy;
    coord_t e_x, e_y, u1_x, u1_y, v1_x, v1_y, u2_x, u2_y, v2_x, v2_y, k_x, k_y;
    logic emit_cmd;

    always_comb
    begin
        off_x = item.relative ? cur_x_reg : '0;
        off_y = item.relative ? cur_y_reg : '0;
        g_ax = sat_add(item.a_x, off_x);
        g_ay = sat_add(item.a_y, off_y);
        g_bx = sat_add(item.b_x, off_x);
        g_by = sat_add(item.b_y, off_y);
        g_cx = sat_add(item.c_x, off_x);
        g_cy = sat_add(item.c_y, off_y);

        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        refl_x_next  = refl_x_reg;
        refl_y_next  = refl_y_reg;
        kind_next    = kind_reg;
        emit_cmd     = 1'b0;
        e_x  = cur_x_reg;
        e_y  = cur_y_reg;
        k_x  = cur_x_reg;
        k_y  = cur_y_reg;
        u1_x = cur_x_reg;
        u1_y = cur_y_reg;
        v1_x = cur_x_reg;
        v1_y = cur_y_reg;
        u2_x = cur_x_reg;
        u2_y = cur_y_reg;
        v2_x = cur_x_reg;
        v2_y = cur_y_reg;

        case (item.mode)
            MODE_MOVE:
            begin
                cur_x_next   = g_ax;
                cur_y_next   = g_ay;
                start_x_next = g_ax;
                start_y_next = g_ay;
                kind_next    = KIND_OTHER;
            end
            MODE_LINE, MODE_HORIZ, MODE_VERT, MODE_CLOSE:
            begin
                case (item.mode)
                    MODE_LINE:
                    begin
                        e_x = g_ax;
                        e_y = g_ay;
                    end
                    MODE_HORIZ:
                    begin
                        e_x = g_ax;
                        e_y = cur_y_reg;
                    end
                    MODE_VERT:
                    begin
                        e_x = cur_x_reg;
                        e_y = g_ay;
                    end
                    default:
                    begin
                        e_x = start_x_reg;
                        e_y = start_y_reg;
                    end
                endcase
                // controls at one and two thirds along the line
                emit_cmd   = 1'b1;
                v1_x       = e_x;
                v1_y       = e_y;
                u2_x       = e_x;
                u2_y       = e_y;
                cur_x_next = e_x;
                cur_y_next = e_y;
                kind_next  = KIND_OTHER;
            end
            MODE_QUAD, MODE_SQUAD:
            begin
                if (item.mode == MODE_QUAD)
                begin
                    k_x = g_ax;
                    k_y = g_ay;
                    e_x = g_bx;
                    e_y = g_by;
                end
                else
                begin
                    k_x = (kind_reg == KIND_QUAD) ? refl_x_reg : cur_x_reg;
                    k_y = (kind_reg == KIND_QUAD) ? refl_y_reg : cur_y_reg;
                    e_x = g_ax;
                    e_y = g_ay;
                end
                emit_cmd    = 1'b1;
                u1_x        = k_x;
                u1_y        = k_y;
                u2_x        = k_x;
                u2_y        = k_y;
                v2_x        = e_x;
                v2_y        = e_y;
                cur_x_next  = e_x;
                cur_y_next  = e_y;
                refl_x_next = reflect(e_x, k_x);
                refl_y_next = reflect(e_y, k_y);
                kind_next   = KIND_QUAD;
            end
            MODE_CUBIC, MODE_SCUBIC:
            begin
                if (item.mode == MODE_CUBIC)
                begin
                    u1_x = g_ax;
                    u1_y = g_ay;
                    k_x  = g_bx;
                    k_y  = g_by;
                    e_x  = g_cx;
                    e_y  = g_cy;
                end
                else
                begin
                    u1_x = (kind_reg == KIND_CUBIC) ? refl_x_reg : cur_x_reg;
                    u1_y = (kind_reg == KIND_CUBIC) ? refl_y_reg : cur_y_reg;
                    k_x  = g_ax;
                    k_y  = g_ay;
                    e_x  = g_bx;
                    e_y  = g_by;
                end
                // blending a point with itself passes it through unchanged
                emit_cmd    = 1'b1;
                v1_x        = u1_x;
                v1_y        = u1_y;
                u2_x        = k_x;
                u2_y        = k_y;
                v2_x        = k_x;
                v2_y        = k_y;
                cur_x_next  = e_x;
                cur_y_next  = e_y;
                refl_x_next = reflect(e_x, k_x);
                refl_y_next = reflect(e_y, k_y);
                kind_next   = KIND_CUBIC;
            end
            default:
            begin
                emit_cmd = 1'b0;
            end
        endcase

        job.emit      = item_vld && emit_cmd;
        job.ends.p0_x = cur_x_reg;
        job.ends.p0_y = cur_y_reg;
        job.ends.p3_x = e_x;
        job.ends.p3_y = e_y;
        job.n1_x      = blend_num(u1_x, v1_x);
        job.n1_y      = blend_num(u1_y, v1_y);
        job.n2_x      = blend_num(u2_x, v2_x);
        job.n2_y      = blend_num(u2_y, v2_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            refl_x_reg  <= '0;
            refl_y_reg  <= '0;
            kind_reg    <= KIND_OTHER;
        end
        else if (fire)
        begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            refl_x_reg  <= refl_x_next;
            refl_y_reg  <= refl_y_next;
            kind_reg    <= kind_next;
        end
    end

endmodule

@@ hdl/pcb_div3.sv @@
// floor(num / 3) - 2^(COORD_W-1): multiply by 0x55..5 through a chain of
// registered shift-adds, then fix the estimate, which is at most one short.
module pcb_div3 (
    input  logic            clk,
    input  logic            en,
    input  pcb_pkg::sum_t   num,
    output pcb_pkg::coord_t quo
);
    import pcb_pkg::*;

    logic [PROD_W-1:0] prod_reg [RECIP_STEPS+1];
    sum_t              num_reg  [RECIP_STEPS+1];
    coord_t            quo_reg;
    sum_t              q_raw, q_fix, rem;

    always_comb
    begin
        q_raw = prod_reg[RECIP_STEPS][2*RECIP_DIGITS +: SUM_W];
        rem   = num_reg[RECIP_STEPS] - q_raw - (q_raw << 1);
        q_fix = (rem >= sum_t'(3)) ? q_raw + sum_t'(1) : q_raw;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= PROD_W'(num);
            num_reg[0]  <= num;
            for (int j = 0; j < RECIP_STEPS; j++)
            begin
                // double the count of base-4 digits of the reciprocal
                prod_reg[j+1] <= prod_reg[j] + (prod_reg[j] << (2 << j));
                num_reg[j+1]  <= num_reg[j];
            end
            // drop the bias by flipping the sign bit
            quo_reg <= {~q_fix[COORD_W-1], q_fix[COORD_W-2:0]};
        end
    end

    assign quo = quo_reg;

endmodule

@@ hdl/path_command_to_cubic_bezier_unit.sv @@
// A segment is registered at accept, then runs through the registered shift-add
// divide-by-3 chain on the control points before its curve turns valid.
// Throughput: one segment per cycle unless the output stalls; move and unknown
// commands give no beat. Reset: pipeline valids clear, current point, subpath start
// and reflection point return to zero, previous command kind returns to other.
module path_command_to_cubic_bezier_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           seg_valid,
    output logic           seg_ready,
    input  pcb_pkg::seg_t  seg,
    output logic           bez_valid,
    input  logic           bez_ready,
    output pcb_pkg::bez_t  bez
);
    import pcb_pkg::*;

    seg_t               seg_reg;
    logic               seg_vld_reg;
    logic               adv;
    logic               fire;
    blend_job_t         job;
    logic [DIV_LAT-1:0] vld_pipe_reg;
    ends_t              ends_pipe_reg [DIV_LAT];
    coord_t             q1_x, q1_y, q2_x, q2_y;

    // hold everything while a finished beat waits
    assign adv       = !bez_valid || bez_ready;
    assign seg_ready = !seg_vld_reg || adv;
    assign fire      = adv && seg_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_vld_reg <= 1'b0;
        else if (seg_ready)
            seg_vld_reg <= seg_valid;
    end

    always_ff @(posedge clk)
    begin
        if (seg_ready && seg_valid)
            seg_reg <= seg;
    end

    pcb_state u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (seg_reg),
        .item_vld (seg_vld_reg),
        .fire     (fire),
        .job      (job)
    );

    pcb_div3 u_div_1x (.clk(clk), .en(adv), .num(job.n1_x), .quo(q1_x));
    pcb_div3 u_div_1y (.clk(clk), .en(adv), .num(job.n1_y), .quo(q1_y));
    pcb_div3 u_div_2x (.clk(clk), .en(adv), .num(job.n2_x), .quo(q2_x));
    pcb_div3 u_div_2y (.clk(clk), .en(adv), .num(job.n2_y), .quo(q2_y));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_pipe_reg <= '0;
        else if (adv)
            vld_pipe_reg <= {vld_pipe_reg[DIV_LAT-2:0], job.emit};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ends_pipe_reg[0] <= job.ends;
            for (int i = 1; i < DIV_LAT; i++)
                ends_pipe_reg[i] <= ends_pipe_reg[i-1];
        end
    end

    assign bez_valid = vld_pipe_reg[DIV_LAT-1];

    always_comb
    begin
        bez.p0_x = ends_pipe_reg[DIV_LAT-1].p0_x;
        bez.p0_y = ends_pipe_reg[DIV_LAT-1].p0_y;
        bez.p1_x = q1_x;
        bez.p1_y = q1_y;
        bez.p2_x = q2_x;
        bez.p2_y = q2_y;
        bez.p3_x = ends_pipe_reg[DIV_LAT-1].p3_x;
        bez.p3_y = ends_pipe_reg[DIV_LAT-1].p3_y;
    end

endmodule

@@ hdl/pcb_checker.sv @@
`include "path_command_to_cubic_bezier_unit_macros.svh"

module pcb_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          seg_valid,
    input logic          seg_ready,
    input logic          bez_valid,
    input logic          bez_ready,
    input pcb_pkg::bez_t bez
);

    // a stalled beat holds
    `PCB_ASSERT_NEXT(a_bez_hold, bez_valid && !bez_ready, bez_valid && $stable(bez))

    // with no beat waiting the input side never stalls
    `PCB_ASSERT_NOW(a_ready_when_empty, !bez_valid, seg_ready)

    // a segment taken under output stall fills the input stage, so ready follows bez_ready
    `PCB_ASSERT_NEXT(a_fill_under_stall, bez_valid && !bez_ready && seg_valid && seg_ready,
        seg_ready == bez_ready)

    // nothing comes out right after reset
    `PCB_ASSERT_NOW(a_quiet_after_reset, $past(!rst_n), !bez_valid)

endmodule

bind path_command_to_cubic_bezier_unit pcb_checker u_pcb_checker (.*);

@@ dv/path_command_to_cubic_bezier_unit_tb.sv @@
module path_command_to_cubic_bezier_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pcb_pkg::*;

    localparam logic [3:0] MODE_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] MODE_UNKNOWN_HI = 4'd15;

    localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam coord_t ONE   = 32'sh0001_0000;

    localparam longint SAT_HI = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    localparam int RANDOM_ITEMS    = 2000;
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct {
        seg_t seg;
        bit   typed;
        bit   emits;
        bez_t curve;
    } step_row_t;

    logic clk;
    logic rst_n;
    logic seg_valid;
    logic seg_ready;
    seg_t seg;
    logic bez_valid;
    logic bez_ready;
    bez_t bez;

    // path state as seen by the predictor
    longint     pen_x, pen_y, sub_x, sub_y, refl_x, refl_y;
    logic [1:0] last_kind;

    step_row_t path_script[$];
    bez_t      curves_due[$];

    int errors;
    int segs_sent;
    int curves_seen;
    int moves_seen;
    int closes_seen;
    int smooth_reflected;
    int ignored_codes;
    int input_stall_cycles;

    path_command_to_cubic_bezier_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .bez_valid (bez_valid),
        .bez_ready (bez_ready),
        .bez       (bez)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint clamp_coord(longint v);
        if (v > SAT_HI)
            return SAT_HI;
        if (v < SAT_LO)
            return SAT_LO;
        return v;
    endfunction

    // (2u + v) / 3 rounded to nearest, floor division
    function automatic longint third_mix(longint u, longint v);
        longint n;
        longint q;
        n = 2 * u + v + 1;
        q = n / 3;
        if (n % 3 < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic bit predict_curve(input seg_t s, output bez_t c);
        longint g[6];
        longint ox, oy, x1, y1, x2, y2, hx, hy, ex, ey;
        bit     emits;
        int     i;
        g[0] = s.a_x;
        g[1] = s.a_y;
        g[2] = s.b_x;
        g[3] = s.b_y;
        g[4] = s.c_x;
        g[5] = s.c_y;
        ox = s.relative ? pen_x : 0;
        oy = s.relative ? pen_y : 0;
        for (i = 0; i < 6; i += 2)
        begin
            g[i]     = clamp_coord(g[i] + ox);
            g[i + 1] = clamp_coord(g[i + 1] + oy);
        end
        emits = 1'b1;
        c = '0;
        ex = 0;
        ey = 0;
        x1 = 0;
        y1 = 0;
        x2 = 0;
        y2 = 0;
        case (s.mode)
            MODE_MOVE:
            begin
                pen_x = g[0];
                pen_y = g[1];
                sub_x = g[0];
                sub_y = g[1];
                last_kind = KIND_OTHER;
                emits = 1'b0;
            end
            MODE_LINE, MODE_HORIZ, MODE_VERT, MODE_CLOSE:
            begin
                ex = g[0];
                ey = g[1];
                if (s.mode == MODE_HORIZ)
                    ey = pen_y;
                if (s.mode == MODE_VERT)
                    ex = pen_x;
                if (s.mode == MODE_CLOSE)
                begin
                    ex = sub_x;
                    ey = sub_y;
                end
                x1 = third_mix(pen_x, ex);
                y1 = third_mix(pen_y, ey);
                x2 = third_mix(ex, pen_x);
                y2 = third_mix(ey, pen_y);
                last_kind = KIND_OTHER;
            end
            MODE_QUAD, MODE_SQUAD:
            begin
                if (s.mode == MODE_QUAD)
                begin
                    hx = g[0];
                    hy = g[1];
                    ex = g[2];
                    ey = g[3];
                end
                else
                begin
                    // reflect only when the previous curve was a quadratic
                    if (last_kind == KIND_QUAD)
                        smooth_reflected++;
                    hx = (last_kind == KIND_QUAD) ? refl_x : pen_x;
                    hy = (last_kind == KIND_QUAD) ? refl_y : pen_y;
                    ex = g[0];
                    ey = g[1];
                end
                x1 = third_mix(hx, pen_x);
                y1 = third_mix(hy, pen_y);
                x2 = third_mix(hx, ex);
                y2 = third_mix(hy, ey);
                refl_x = clamp_coord(2 * ex - hx);
                refl_y = clamp_coord(2 * ey - hy);
                last_kind = KIND_QUAD;
            end
            MODE_CUBIC, MODE_SCUBIC:
            begin
                if (s.mode == MODE_CUBIC)
                begin
                    x1 = g[0];
                    y1 = g[1];
                    x2 = g[2];
                    y2 = g[3];
                    ex = g[4];
                    ey = g[5];
                end
                else
                begin
                    if (last_kind == KIND_CUBIC)
                        smooth_reflected++;
                    x1 = (last_kind == KIND_CUBIC) ? refl_x : pen_x;
                    y1 = (last_kind == KIND_CUBIC) ? refl_y : pen_y;
                    x2 = g[0];
                    y2 = g[1];
                    ex = g[2];
                    ey = g[3];
                end
                refl_x = clamp_coord(2 * ex - x2);
                refl_y = clamp_coord(2 * ey - y2);
                last_kind = KIND_CUBIC;
            end
            default:
            begin
                ignored_codes++;
                emits = 1'b0;
            end
        endcase
        if (emits)
        begin
            c.p0_x = coord_t'(pen_x);
            c.p0_y = coord_t'(pen_y);
            c.p1_x = coord_t'(x1);
            c.p1_y = coord_t'(y1);
            c.p2_x = coord_t'(x2);
            c.p2_y = coord_t'(y2);
            c.p3_x = coord_t'(ex);
            c.p3_y = coord_t'(ey);
            pen_x = ex;
            pen_y = ey;
        end
        return emits;
    endfunction

    function automatic void add_seg(logic [3:0] m, bit rel, coord_t ax, coord_t ay,
                                    coord_t bx, coord_t by, coord_t cx, coord_t cy);
        step_row_t r;
        r.seg.mode = m;
        r.seg.relative = rel;
        r.seg.a_x = ax;
        r.seg.a_y = ay;
        r.seg.b_x = bx;
        r.seg.b_y = by;
        r.seg.c_x = cx;
        r.seg.c_y = cy;
        r.typed = 1'b0;
        r.emits = 1'b0;
        r.curve = '0;
        path_script = {path_script, r};
    endfunction

    function automatic void pin_curve(bez_t c);
        path_script[path_script.size() - 1].typed = 1'b1;
        path_script[path_script.size() - 1].emits = 1'b1;
        path_script[path_script.size() - 1].curve = c;
    endfunction

    function automatic void pin_none();
        path_script[path_script.size() - 1].typed = 1'b1;
        path_script[path_script.size() - 1].emits = 1'b0;
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3, 4, 5: return coord_t'($urandom);
            default: return coord_t'($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
        endcase
    endfunction

    // stretches of back-to-back beats, otherwise a random idle gap before the beat
    function automatic int draw_wait(int n);
        if (n % 150 < 40)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    function automatic void match_coord(string name, coord_t want, coord_t got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: mismatch in %s: expected %h, got %h", $time, name, want, got);
        end
    endfunction

    function automatic void check_curve(bez_t got);
        bez_t want;
        curves_seen++;
        if (curves_due.size() == 0)
        begin
            errors++;
            $display("%0t: curve with nothing pending: expected none, got %h", $time, got);
            return;
        end
        want = curves_due[0];
        curves_due.delete(0);
        match_coord("p0_x", want.p0_x, got.p0_x);
        match_coord("p0_y", want.p0_y, got.p0_y);
        match_coord("p1_x", want.p1_x, got.p1_x);
        match_coord("p1_y", want.p1_y, got.p1_y);
        match_coord("p2_x", want.p2_x, got.p2_x);
        match_coord("p2_y", want.p2_y, got.p2_y);
        match_coord("p3_x", want.p3_x, got.p3_x);
        match_coord("p3_y", want.p3_y, got.p3_y);
    endfunction

    task automatic offer_segment(input step_row_t r, input int gap);
        bez_t c;
        bit   emits;
        if (gap > 0)
        begin
            seg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seg_valid <= 1'b1;
        seg <= r.seg;
        do
            @(posedge clk);
        while (!seg_ready);
        emits = predict_curve(r.seg, c);
        if (r.typed)
        begin
            emits = r.emits;
            c = r.curve;
        end
        if (emits)
            curves_due = {curves_due, c};
        if (r.seg.mode == MODE_MOVE)
            moves_seen++;
        if (r.seg.mode == MODE_CLOSE)
            closes_seen++;
        segs_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && seg_valid && !seg_ready)
            input_stall_cycles++;
    end

    // output side: random stalls plus one long hold-off to back up the pipeline
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (curves_seen == HOLD_OFF_AT)
                stall = HOLD_OFF_CYCLES;
            else
                stall = draw_wait(curves_seen + 75);
            if (stall > 0)
            begin
                bez_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            bez_ready <= 1'b1;
            do
                @(posedge clk);
            while (!bez_valid);
            check_curve(bez);
        end
    end

    initial
    begin
        #10_000_000;
        $display("Timeout: %0d curves still pending", curves_due.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        step_row_t  r;
        logic [3:0] m;
        logic [3:0] prev_m;
        int         pick;
        int         drawn;
        rst_n <= 1'b0;
        seg_valid <= 1'b0;
        seg <= '0;
        bez_ready <= 1'b0;
        pen_x = 0;
        pen_y = 0;
        sub_x = 0;
        sub_y = 0;
        refl_x = 0;
        refl_y = 0;
        last_kind = KIND_OTHER;

        add_seg(MODE_LINE, 1'b0, 32'sh0003_0000, 32'sh0006_0000, '0, '0, '0, '0);
        pin_curve('{32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0002_0000,
                    32'sh0002_0000, 32'sh0004_0000, 32'sh0003_0000, 32'sh0006_0000});
        add_seg(MODE_UNKNOWN_HI, 1'b1, C_MAX, C_MIN, ONE, ONE, ONE, ONE);
        pin_none();
        add_seg(MODE_UNKNOWN_LO, 1'b0, ONE, -ONE, C_MIN, C_MAX, '0, '0);
        pin_none();
        add_seg(MODE_MOVE, 1'b0, C_MAX, C_MAX, ONE, ONE, ONE, ONE);
        pin_none();
        // relative sum saturates at the top of the range
        add_seg(MODE_LINE, 1'b1, ONE, ONE, '0, '0, '0, '0);
        pin_curve('{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX});
        add_seg(MODE_MOVE, 1'b1, C_MIN, C_MIN, '0, '0, '0, '0);
        pin_none();
        add_seg(MODE_LINE, 1'b1, C_MIN, C_MIN, ONE, ONE, ONE, ONE);
        add_seg(MODE_HORIZ, 1'b0, C_MAX, 32'sh1234_5678, C_MIN, C_MAX, '0, '0);
        add_seg(MODE_VERT, 1'b1, C_MIN, ONE, C_MAX, '0, '0, '0);
        add_seg(MODE_QUAD, 1'b0, 32'sh0002_0000, 32'sh0004_0000,
                -32'sh0003_0000, ONE, '0, '0);
        add_seg(MODE_SQUAD, 1'b0, 32'sh0005_0000, -32'sh0002_0000, C_MAX, C_MAX, '0, '0);
        add_seg(MODE_SQUAD, 1'b1, -32'sh0000_8000, 32'sh0000_7fff, '0, '0, '0, '0);
        add_seg(MODE_CUBIC, 1'b0, ONE, -ONE, 32'sh0007_1234, 32'sh0000_0001,
                -32'sh0010_0000, 32'sh0020_0000);
        add_seg(MODE_SCUBIC, 1'b0, 32'sh0001_8000, 32'sh0002_8000,
                32'sh0003_0000, -32'sh0004_0000, C_MIN, C_MAX);
        // smooth commands after the other curve kind fall back to the pen
        add_seg(MODE_SQUAD, 1'b0, -32'sh0006_0000, 32'sh0000_0003, '0, '0, '0, '0);
        add_seg(MODE_SCUBIC, 1'b1, ONE, ONE, -ONE, 32'sh0002_0000, '0, '0);
        add_seg(MODE_CLOSE, 1'b1, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        add_seg(MODE_MOVE, 1'b1, ONE, -ONE, '0, '0, '0, '0);
        add_seg(MODE_CUBIC, 1'b1, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        add_seg(MODE_SCUBIC, 1'b1, C_MAX, C_MAX, C_MIN, C_MAX, '0, '0);
        // reflection of extreme points saturates
        add_seg(MODE_QUAD, 1'b0, C_MIN, C_MAX, C_MAX, C_MIN, '0, '0);
        add_seg(MODE_SQUAD, 1'b0, C_MIN, C_MAX, '0, '0, '0, '0);
        add_seg(MODE_CLOSE, 1'b0, '0, '0, '0, '0, '0, '0);
        add_seg(MODE_MOVE, 1'b0, '0, '0, C_MIN, C_MIN, C_MIN, C_MIN);
        pin_none();
        add_seg(MODE_CLOSE, 1'b0, C_MAX, C_MIN, '0, '0, '0, '0);
        pin_curve('0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (path_script[i])
            offer_segment(path_script[i], draw_wait(segs_sent));

        prev_m = MODE_MOVE;
        drawn = 0;
        r.typed = 1'b0;
        r.emits = 1'b0;
        r.curve = '0;
        while (drawn < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                m = MODE_MOVE;
            else if (pick < 13)
                m = MODE_CLOSE;
            else if (pick < 17)
                m = 4'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
            else if (pick < 40 && (prev_m == MODE_QUAD || prev_m == MODE_SQUAD))
                m = MODE_SQUAD;
            else if (pick < 40 && (prev_m == MODE_CUBIC || prev_m == MODE_SCUBIC))
                m = MODE_SCUBIC;
            else
                m = 4'($urandom_range(MODE_LINE, MODE_SCUBIC));
            r.seg.mode = m;
            r.seg.relative = 1'($urandom_range(0, 1));
            r.seg.a_x = pick_coord();
            r.seg.a_y = pick_coord();
            r.seg.b_x = pick_coord();
            r.seg.b_y = pick_coord();
            r.seg.c_x = pick_coord();
            r.seg.c_y = pick_coord();
            offer_segment(r, draw_wait(segs_sent));
            if (m < MODE_UNKNOWN_LO)
                drawn++;
            prev_m = m;
        end
        seg_valid <= 1'b0;

        while (curves_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d segments: %0d moves, %0d closes, %0d reflected smooth curves",
                 segs_sent, moves_seen, closes_seen, smooth_reflected);
        $display("%0d curves checked, %0d ignored codes, input held back for %0d cycles",
                 curves_seen, ignored_codes, input_stall_cycles);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/pcb_pkg.sv
hdl/pcb_state.sv
hdl/pcb_div3.sv
hdl/path_command_to_cubic_bezier_unit.sv
hdl/pcb_checker.sv
dv/path_command_to_cubic_bezier_unit_tb.sv
